/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the forward kinematics unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define FKIN_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FKIN_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/fkin_pkg.sv */
// Shared constants, types and rounding helpers of the forward kinematics unit.
`default_nettype none
package fkin_pkg;
  localparam int WORK_BITS     = 30;
  localparam int JOINTS        = 7;
  localparam int LINK_COUNT    = 10;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ANGLE_W       = 20;
  localparam int OUT_W         = 18;
  localparam int SC_W          = 32;
  localparam int ROT_W         = 34;
  localparam int POS_W         = 34;
  localparam int PROD_W        = 68;
  localparam int TERMS         = 6;
  localparam int IN_DATA_W     = ((JOINTS * ANGLE_W + 7) / 8) * 8;
  localparam int OUT_ITEMS     = 12;
  localparam int OUT_DATA_W    = ((OUT_ITEMS * OUT_W + 7) / 8) * 8;

  localparam longint ONE_Q        = 64'sd1 << WORK_BITS;
  localparam longint PI_Q         = 64'sd3373259426;
  localparam longint HALF_PI_Q    = 64'sd1686629713;
  localparam longint QUARTER_PI_Q = 64'sd843314857;
  localparam longint TWO_PI_Q     = 64'sd6746518852;
  localparam longint HALF_SQRT2_Q = 64'sd759250125;

  // Series divisors per term; the sine series has one term fewer.
  localparam int SIN_DIV [TERMS] = '{6, 20, 42, 72, 110, 1};
  localparam int COS_DIV [TERMS] = '{2, 12, 30, 56, 90, 132};

  localparam longint LINK_A [LINK_COUNT] =
    '{0, 0, 0, 88583700, -88583700, 0, 94489281, 0, 0, 0};
  localparam longint LINK_D [LINK_COUNT] =
    '{357556027, 0, 339302416, 0, 412316860, 0, 0, 114890375, 0, 111024905};
  localparam int LINK_CA [LINK_COUNT] = '{1, 0, 0, 0, 0, 0, 0, 1, 1, 1};
  localparam int LINK_SA [LINK_COUNT] = '{0, -1, 1, 1, -1, 1, 1, 0, 0, 0};
  localparam longint FIXED_C [LINK_COUNT - JOINTS] = '{ONE_Q, HALF_SQRT2_Q, ONE_Q};
  localparam longint FIXED_S [LINK_COUNT - JOINTS] = '{0, -HALF_SQRT2_Q, 0};

  typedef struct packed {
    logic signed [SC_W-1:0] sin_v;
    logic signed [SC_W-1:0] cos_v;
  } sc_t;

  typedef sc_t [JOINTS-1:0] sc_arr_t;

  typedef struct packed {
    logic neg_s;
    logic neg_c;
    logic swap;
  } fold_t;

  typedef struct packed {
    logic signed [SC_W-1:0] t_s;
    logic signed [SC_W-1:0] sum_s;
    logic signed [SC_W-1:0] t_c;
    logic signed [SC_W-1:0] sum_c;
    logic [SC_W-2:0]        x2;
    fold_t                  fold;
  } taylor_t;

  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] rot;
    logic [2:0][POS_W-1:0]      pos;
  } pose_t;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v, input int sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] half;
    half = PROD_W'(1) << (sh - 1);
    mag  = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    mag  = (mag + half) >> sh;
    return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
  endfunction
endpackage
`default_nettype wire

/* rtl/fkin_term.sv */
// One series term of the sine and cosine evaluation: multiply, round, divide, accumulate.
`default_nettype none
module fkin_term #(
  parameter int SIN_D  = 6,
  parameter int COS_D  = 2,
  parameter bit SIN_ON = 1'b1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fkin_pkg::taylor_t st_in,
  output logic              out_valid,
  output fkin_pkg::taylor_t st_out
);
  import fkin_pkg::*;

  localparam int SS = SC_W - 1 + $clog2(SIN_D);
  localparam int SC = SC_W - 1 + $clog2(COS_D);
  localparam logic [63:0] MS = ((64'd1 << SS) + 64'(SIN_D) - 64'd1) / 64'(SIN_D);
  localparam logic [63:0] MC = ((64'd1 << SC) + 64'(COS_D) - 64'd1) / 64'(COS_D);
  localparam logic [63:0] HALF = 64'd1 << (WORK_BITS - 1);

  logic v_p, v_r, v_d;
  taylor_t st_p, st_r, st_d;
  taylor_t st_next;
  logic signed [63:0] prod_s, prod_c;
  logic [SC_W-2:0] mag_s, mag_c;
  logic neg_s_r, neg_c_r, neg_s_d, neg_c_d;
  logic [63:0] qp_s, qp_c;
  logic signed [SC_W-1:0] q_s, q_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      v_r <= 1'b0;
      v_d <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_p <= in_valid;
      v_r <= v_p;
      v_d <= v_r;
      out_valid <= v_d;
    end
  end

  assign q_s = SC_W'(qp_s >> SS);
  assign q_c = SC_W'(qp_c >> SC);

  // negate and accumulate
  always_comb begin
    st_next = st_d;
    if (SIN_ON) begin
      st_next.t_s   = neg_s_d ? q_s : -q_s;
      st_next.sum_s = st_d.sum_s + (neg_s_d ? q_s : -q_s);
    end
    st_next.t_c   = neg_c_d ? q_c : -q_c;
    st_next.sum_c = st_d.sum_c + (neg_c_d ? q_c : -q_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // multiply by x^2
      st_p   <= st_in;
      prod_s <= st_in.t_s * $signed({1'b0, st_in.x2});
      prod_c <= st_in.t_c * $signed({1'b0, st_in.x2});
      // round the product, keep sign and magnitude
      st_r    <= st_p;
      neg_s_r <= prod_s[63];
      neg_c_r <= prod_c[63];
      mag_s   <= (SC_W-1)'(((prod_s[63] ? 64'(-prod_s) : 64'(prod_s)) + HALF) >> WORK_BITS);
      mag_c   <= (SC_W-1)'(((prod_c[63] ? 64'(-prod_c) : 64'(prod_c)) + HALF) >> WORK_BITS);
      // divide by reciprocal multiply
      st_d    <= st_r;
      neg_s_d <= neg_s_r;
      neg_c_d <= neg_c_r;
      qp_s    <= 64'(mag_s) * MS;
      qp_c    <= 64'(mag_c) * MC;
      st_out  <= st_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/fkin_sincos.sv */
// Sine and cosine of one joint angle: range reduction, folding and series terms.
`default_nettype none
module fkin_sincos #(
  parameter int FRAC_BITS = fkin_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [fkin_pkg::ANGLE_W-1:0]    angle,
  output logic                                   out_valid,
  output fkin_pkg::sc_t                          sc
);
  import fkin_pkg::*;

  localparam int SHIFT = WORK_BITS - FRAC_BITS;
  localparam int ANG_W = (ANGLE_W + SHIFT + 2 > 37) ? ANGLE_W + SHIFT + 2 : 37;
  localparam logic signed [ANG_W-1:0] PI_A     = ANG_W'(PI_Q);
  localparam logic signed [ANG_W-1:0] TWO_PI_A = ANG_W'(TWO_PI_Q);
  localparam logic signed [ANG_W-1:0] HALF_A   = ANG_W'(HALF_PI_Q);
  localparam logic [SC_W-2:0] HALF_U    = (SC_W-1)'(HALF_PI_Q);
  localparam logic [SC_W-2:0] QUARTER_U = (SC_W-1)'(QUARTER_PI_Q);
  localparam logic [2*SC_W-3:0] X2_HALF = (2*SC_W-2)'(1) << (WORK_BITS - 1);

  logic [6:0] v;
  logic signed [ANG_W-1:0] a0, a1, a2;
  logic neg_c2, neg_c3, neg_c4, neg_s3, neg_s4, swap4;
  logic [SC_W-2:0] b3, x4;
  logic [2*SC_W-3:0] xx5;
  logic [SC_W-2:0] xx5_x;
  fold_t fold5;
  taylor_t chain [TERMS+1];
  logic [TERMS:0] chain_v;
  logic signed [SC_W-1:0] sf, cf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
      out_valid <= chain_v[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= ANG_W'(angle) <<< SHIFT;
      // bring into [-pi, pi]
      if (a0 > PI_A) begin
        a1 <= a0 - TWO_PI_A;
      end else if (a0 < -PI_A) begin
        a1 <= a0 + TWO_PI_A;
      end else begin
        a1 <= a0;
      end
      // fold into [-pi/2, pi/2]
      if (a1 > HALF_A) begin
        a2 <= PI_A - a1;
        neg_c2 <= 1'b1;
      end else if (a1 < -HALF_A) begin
        a2 <= -PI_A - a1;
        neg_c2 <= 1'b1;
      end else begin
        a2 <= a1;
        neg_c2 <= 1'b0;
      end
      neg_s3 <= a2[ANG_W-1];
      neg_c3 <= neg_c2;
      b3 <= (SC_W-1)'(a2[ANG_W-1] ? -a2 : a2);
      neg_s4 <= neg_s3;
      neg_c4 <= neg_c3;
      swap4 <= b3 > QUARTER_U;
      x4 <= (b3 > QUARTER_U) ? HALF_U - b3 : b3;
      xx5 <= (2*SC_W-2)'(x4) * (2*SC_W-2)'(x4);
      fold5 <= '{neg_s: neg_s4, neg_c: neg_c4, swap: swap4};
      chain[0].x2 <= (SC_W-1)'((xx5 + X2_HALF) >> WORK_BITS);
      chain[0].t_s <= SC_W'(xx5_x);
      chain[0].sum_s <= SC_W'(xx5_x);
      chain[0].t_c <= SC_W'(ONE_Q);
      chain[0].sum_c <= SC_W'(ONE_Q);
      chain[0].fold <= fold5;
    end
  end

  // x travels beside its square for one stage
  always_ff @(posedge clk) begin
    if (en) begin
      xx5_x <= x4;
    end
  end

  assign chain_v[0] = v[6];

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    fkin_term #(
      .SIN_D  (SIN_DIV[k]),
      .COS_D  (COS_DIV[k]),
      .SIN_ON (k < TERMS - 1)
    ) u_term (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_v[k]),
      .st_in     (chain[k]),
      .out_valid (chain_v[k+1]),
      .st_out    (chain[k+1])
    );
  end

  // undo the quarter swap and the signs
  always_comb begin
    sf = chain[TERMS].fold.swap ? chain[TERMS].sum_c : chain[TERMS].sum_s;
    cf = chain[TERMS].fold.swap ? chain[TERMS].sum_s : chain[TERMS].sum_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.sin_v <= chain[TERMS].fold.neg_s ? -sf : sf;
      sc.cos_v <= chain[TERMS].fold.neg_c ? -cf : cf;
    end
  end
endmodule
`default_nettype wire

/* rtl/fkin_link.sv */
// One link transform applied to the running pose, three register stages.
`default_nettype none
module fkin_link #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fkin_pkg::pose_t   pose_in,
  input  fkin_pkg::sc_arr_t sc_in,
  output logic              out_valid,
  output fkin_pkg::pose_t   pose_out,
  output fkin_pkg::sc_arr_t sc_out
);
  import fkin_pkg::*;

  localparam int CA = LINK_CA[IDX];
  localparam int SA = LINK_SA[IDX];
  localparam logic signed [SC_W-1:0] A_C = SC_W'(LINK_A[IDX]);
  localparam logic signed [SC_W-1:0] D_C = SC_W'(LINK_D[IDX]);

  logic signed [SC_W-1:0] c, s;
  logic signed [ROT_W-1:0] u [3];
  logic signed [ROT_W-1:0] vv [3];
  logic signed [ROT_W-1:0] w [3];
  logic v1, v2;
  logic signed [PROD_W-1:0] p_uc [3], p_vs [3], p_vc [3], p_us [3], p_ua [3], p_wd [3];
  logic signed [PROD_W-1:0] s0 [3], s1 [3], sp [3];
  logic signed [ROT_W-1:0] w1 [3], w2 [3];
  logic [2:0][POS_W-1:0] pos1, pos2;
  sc_arr_t sc1, sc2;

  if (IDX < JOINTS) begin : g_joint
    assign c = sc_in[IDX].cos_v;
    assign s = sc_in[IDX].sin_v;
  end else begin : g_fixed
    assign c = SC_W'(FIXED_C[IDX-JOINTS]);
    assign s = SC_W'(FIXED_S[IDX-JOINTS]);
  end

  // pick the operands the link's twist routes into each column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      u[r] = $signed(pose_in.rot[r][0]);
      if (CA == 1) begin
        vv[r] = $signed(pose_in.rot[r][1]);
        w[r]  = $signed(pose_in.rot[r][2]);
      end else if (SA == 1) begin
        vv[r] = $signed(pose_in.rot[r][2]);
        w[r]  = -$signed(pose_in.rot[r][1]);
      end else begin
        vv[r] = -$signed(pose_in.rot[r][2]);
        w[r]  = $signed(pose_in.rot[r][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc1 <= sc_in;
      sc2 <= sc1;
      sc_out <= sc2;
      pos1 <= pose_in.pos;
      pos2 <= pos1;
      for (int r = 0; r < 3; r++) begin
        p_uc[r] <= u[r] * c;
        p_vs[r] <= vv[r] * s;
        p_vc[r] <= vv[r] * c;
        p_us[r] <= u[r] * s;
        p_ua[r] <= u[r] * A_C;
        p_wd[r] <= w[r] * D_C;
        w1[r]   <= w[r];
        s0[r]   <= p_uc[r] + p_vs[r];
        s1[r]   <= p_vc[r] - p_us[r];
        sp[r]   <= p_ua[r] + p_wd[r];
        w2[r]   <= w1[r];
        pose_out.rot[r][0] <= ROT_W'(round_shift(s0[r], WORK_BITS));
        pose_out.rot[r][1] <= ROT_W'(round_shift(s1[r], WORK_BITS));
        pose_out.rot[r][2] <= w2[r];
        pose_out.pos[r] <= POS_W'(round_shift(sp[r], WORK_BITS)
                                  + PROD_W'($signed(pos2[r])));
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/arm_forward_kinematics_unit.sv */
// Top level of the seven-axis forward kinematics unit.
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) carries one request per
//   transfer: seven joint angles, signed Q3.16 radians at the default
//   fraction width, 20 bits each, joint 1 in the lowest bits.
//   The master channel (m_tvalid, m_tready, m_tdata) returns one pose per
//   request, in request order: nine rotation entries row major, then x, y, z,
//   18 bits each, signed Q1.16, saturated at the range ends.
//   From acceptance to m_tvalid a request passes 7 stages of angle
//   reduction, 24 of series terms (six terms of four stages), one of sign
//   fix-up, 30 of link transforms (ten links of three stages), one rounding
//   stage and the output register.
//   Throughput is one request per cycle unless stalled; every stage holds
//   a valid bit. When the receiver stalls with a result waiting, the whole
//   pipeline holds and s_tready drops; no request is lost or repeated.
//   Reset clears every valid bit; the data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module arm_forward_kinematics_unit #(
  parameter int FRAC_BITS = fkin_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // angle_j1 .. angle_j7, then zero padding
  input  logic [fkin_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // pos_x, pos_y, pos_z
  output logic [fkin_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import fkin_pkg::*;

  localparam int OUT_SHIFT = WORK_BITS - FRAC_BITS;
  localparam logic signed [POS_W-1:0] SAT_HI = POS_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [POS_W-1:0] SAT_LO = -SAT_HI - POS_W'(1);

  logic adv;
  logic [JOINTS-1:0] sc_v;
  sc_arr_t sc_all;
  pose_t pose0;
  pose_t link_pose [LINK_COUNT+1];
  sc_arr_t link_sc [LINK_COUNT+1];
  logic [LINK_COUNT:0] link_v;
  logic conv_v;
  logic signed [POS_W-1:0] conv [OUT_ITEMS];

  function automatic logic [OUT_W-1:0] sat(input logic signed [POS_W-1:0] x);
    if (x > SAT_HI) begin
      return OUT_W'(SAT_HI);
    end else if (x < SAT_LO) begin
      return OUT_W'(SAT_LO);
    end
    return OUT_W'(x);
  endfunction

  // Advance everything when the output register is free or being drained.
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  for (genvar j = 0; j < JOINTS; j++) begin : g_joint
    fkin_sincos #(
      .FRAC_BITS (FRAC_BITS)
    ) u_sincos (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (s_tvalid),
      .angle     ($signed(s_tdata[j*ANGLE_W +: ANGLE_W])),
      .out_valid (sc_v[j]),
      .sc        (sc_all[j])
    );
  end

  // Start every request from the identity pose.
  always_comb begin
    pose0 = '0;
    for (int i = 0; i < 3; i++) begin
      pose0.rot[i][i] = ROT_W'(ONE_Q);
    end
  end

  assign link_pose[0] = pose0;
  assign link_sc[0]   = sc_all;
  assign link_v[0]    = &sc_v;

  for (genvar i = 0; i < LINK_COUNT; i++) begin : g_link
    fkin_link #(
      .IDX (i)
    ) u_link (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (link_v[i]),
      .pose_in   (link_pose[i]),
      .sc_in     (link_sc[i]),
      .out_valid (link_v[i+1]),
      .pose_out  (link_pose[i+1]),
      .sc_out    (link_sc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      conv_v   <= link_v[LINK_COUNT];
      m_tvalid <= conv_v;
    end
  end

  // Round to the output fraction width, then clamp into the output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          conv[r*3+j] <= POS_W'(round_shift(
              PROD_W'($signed(link_pose[LINK_COUNT].rot[r][j])), OUT_SHIFT));
        end
        conv[9+r] <= POS_W'(round_shift(
            PROD_W'($signed(link_pose[LINK_COUNT].pos[r])), OUT_SHIFT));
      end
      for (int k = 0; k < OUT_ITEMS; k++) begin
        m_tdata[k*OUT_W +: OUT_W] <= sat(conv[k]);
      end
    end
  end

  `FKIN_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result valid right after reset")
  `FKIN_ASSERT_NEXT(a_stall_holds, clk, rst, !s_tready, $stable(link_v) && $stable(conv_v), "pipeline moved while stalled")
  `FKIN_ASSERT_SAME(a_joints_aligned, clk, rst, 1'b1, (sc_v == '0) || (sc_v == '1), "joint units out of step")
endmodule
`default_nettype wire

/* bench/fkin_pose_checker.sv */
// Pose checker: predicts each request's pose and compares it with the returned pose.
`default_nettype none
module fkin_pose_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  input  wire logic                                 s_tready,
  // angle_j1 .. angle_j7, then zero padding
  input  wire logic [fkin_pkg::IN_DATA_W-1:0]       s_tdata,
  input  wire logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  // rot_00 .. rot_22, pos_x, pos_y, pos_z
  input  wire logic [fkin_pkg::OUT_DATA_W-1:0]      m_tdata,
  output int                                        fail_count,
  output int                                        poses_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fkin_pkg::*;

  typedef logic [OUT_ITEMS-1:0][OUT_W-1:0] pose_word_t;

  pose_word_t pending_poses[$];

  string field_names [OUT_ITEMS] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11",
    "rot_12", "rot_20", "rot_21", "rot_22", "pos_x", "pos_y", "pos_z"};

  // Round to nearest, ties away from zero.
  function automatic longint shift_round(longint v, int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // Series on [-pi/4, pi/4]; each term is derived from the previous one.
  function automatic void series_sincos(input longint x, output longint sn,
                                        output longint cs);
    longint x2, t;
    x2 = shift_round(x * x, WORK_BITS);
    t  = x;
    sn = x;
    for (int k = 1; k <= 5; k++) begin
      t  = -(shift_round(t * x2, WORK_BITS) / longint'((2 * k) * (2 * k + 1)));
      sn += t;
    end
    t  = ONE_Q;
    cs = ONE_Q;
    for (int k = 1; k <= 6; k++) begin
      t  = -(shift_round(t * x2, WORK_BITS) / longint'((2 * k - 1) * (2 * k)));
      cs += t;
    end
  endfunction

  // Reduce into [-pi, pi], fold into [-pi/2, pi/2], swap above pi/4.
  function automatic void joint_sincos(input longint a, output longint sn,
                                       output longint cs);
    bit     flip_c, flip_s;
    longint b, s, c;
    flip_c = 0;
    if (a > PI_Q) a -= TWO_PI_Q;
    if (a < -PI_Q) a += TWO_PI_Q;
    if (a > HALF_PI_Q) begin
      a = PI_Q - a;
      flip_c = 1;
    end else if (a < -HALF_PI_Q) begin
      a = -PI_Q - a;
      flip_c = 1;
    end
    flip_s = a < 0;
    b = flip_s ? -a : a;
    if (b > QUARTER_PI_Q) series_sincos(HALF_PI_Q - b, c, s);
    else series_sincos(b, s, c);
    sn = flip_s ? -s : s;
    cs = flip_c ? -c : c;
  endfunction

  function automatic logic [OUT_W-1:0] to_output(longint v);
    longint r;
    r = shift_round(v, WORK_BITS - FRAC_BITS_DEF);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[OUT_W-1:0];
  endfunction

  // Chain the ten link transforms and convert the pose to output fields.
  function automatic pose_word_t compute_pose(logic [IN_DATA_W-1:0] angles);
    longint rot [3][3];
    longint pos [3];
    longint lr [3][3];
    longint lp [3];
    longint nr [3][3];
    longint np [3];
    longint c, s, ca, sa, acc, sum;
    pose_word_t pose;
    foreach (rot[r, j]) rot[r][j] = (r == j) ? ONE_Q : 0;
    foreach (pos[r]) pos[r] = 0;
    for (int i = 0; i < LINK_COUNT; i++) begin
      ca = LINK_CA[i];
      sa = LINK_SA[i];
      if (i < JOINTS) begin
        joint_sincos(longint'($signed(angles[i*ANGLE_W +: ANGLE_W]))
                     <<< (WORK_BITS - FRAC_BITS_DEF), s, c);
      end else begin
        c = FIXED_C[i - JOINTS];
        s = FIXED_S[i - JOINTS];
      end
      lr[0][0] = c;      lr[0][1] = -s;     lr[0][2] = 0;
      lr[1][0] = s * ca; lr[1][1] = c * ca; lr[1][2] = -sa * ONE_Q;
      lr[2][0] = s * sa; lr[2][1] = c * sa; lr[2][2] = ca * ONE_Q;
      lp[0] = LINK_A[i];
      lp[1] = -sa * LINK_D[i];
      lp[2] = ca * LINK_D[i];
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += rot[r][k] * lr[k][j];
          nr[r][j] = shift_round(sum, WORK_BITS);
        end
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[r][k] * lp[k];
        np[r] = shift_round(acc, WORK_BITS) + pos[r];
      end
      rot = nr;
      pos = np;
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) pose[r*3 + j] = to_output(rot[r][j]);
      pose[9 + r] = to_output(pos[r]);
    end
    return pose;
  endfunction

  always_ff @(posedge clk) begin
    pose_word_t want, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_ITEMS*OUT_W-1:0];
        if (pending_poses.size() == 0) begin
          $display("%0t: pose returned with no request waiting: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_poses.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            for (int f = 0; f < OUT_ITEMS; f++)
              if (want[f] != got[f])
                $display("%0t: %s expected %0d actual %0d", $time, field_names[f],
                         $signed(want[f]), $signed(got[f]));
          end
        end
      end
      if (s_tvalid && s_tready) pending_poses.push_back(compute_pose(s_tdata));
    end
  end

  assign poses_pending = pending_poses.size();
endmodule
`default_nettype wire

/* bench/tb_arm_forward_kinematics_unit.sv */
// Testbench top: drives angle requests, stalls the pose channel and reports the verdict.
`default_nettype none
module tb_arm_forward_kinematics_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fkin_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_REQS  = 850;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic in_taken = 0;
  int fail_count, poses_pending;
  int tx_idle_pct = 7, rx_idle_pct = 73;
  int quiet_cycles = 0;

  // Angles at the reduction, fold and swap boundaries (pi, pi/2, pi/4 in Q3.16).
  logic signed [ANGLE_W-1:0] edge_angles [15] = '{0, 524287, -524288, 205887, -205887,
    205888, -205888, 102944, 102945, -102944, 51472, 51473, -51472, 1, -1};

  always #10 clk = ~clk;

  arm_forward_kinematics_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fkin_pose_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .poses_pending(poses_pending)
  );

  // Stall the pose channel at random, per the current idle rate.
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  // Record whether the request was taken at this rising edge.
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Hold the request until it is accepted; idle first at random.
  task automatic send_request(input logic [JOINTS-1:0][ANGLE_W-1:0] angles);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata  = {{(IN_DATA_W - JOINTS*ANGLE_W){1'b0}}, angles};
    do @(negedge clk); while (!in_taken);
    s_tvalid = 0;
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    case ($urandom_range(3))
      0: return ANGLE_W'($urandom);
      1: return ANGLE_W'($signed($urandom_range(411774)) - 205887);
      2: return edge_angles[$urandom_range(14)] + ANGLE_W'($signed($urandom_range(4)) - 2);
      default: return ANGLE_W'($signed($urandom_range(8191)) - 4096);
    endcase
  endfunction

  initial begin
    logic [JOINTS-1:0][ANGLE_W-1:0] angles;
    repeat (6) @(negedge clk);
    rst = 0;

    // Directed: boundary angles on all joints, alternating bit patterns, a boundary mix.
    foreach (edge_angles[e]) begin
      for (int j = 0; j < JOINTS; j++) angles[j] = edge_angles[e];
      send_request(angles);
    end
    for (int j = 0; j < JOINTS; j++) angles[j] = j[0] ? 20'hAAAAA : 20'h55555;
    send_request(angles);
    for (int j = 0; j < JOINTS; j++) angles[j] = j[0] ? 20'h55555 : 20'hAAAAA;
    send_request(angles);
    for (int j = 0; j < JOINTS; j++) angles[j] = edge_angles[(j * 3) % 15];
    send_request(angles);

    // Random: three idle profiles.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        tx_idle_pct = 73;
        rx_idle_pct = 7;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int j = 0; j < JOINTS; j++) angles[j] = random_angle();
      send_request(angles);
    end

    wait (poses_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
